[hdl/ptg_pkg.sv]
`default_nettype none
package ptg_pkg;

  localparam int SECTOR_COUNT = 200;
  localparam int MAX_RINGS    = 128;
  localparam int TRIG_BITS    = 16;

  localparam int TRIG_FRAC = TRIG_BITS - 2;
  localparam int TMAG_W    = TRIG_BITS - 1;
  localparam int SIDX_W    = (SECTOR_COUNT > 1) ? $clog2(SECTOR_COUNT) : 1;

  localparam int RING_W  = 7;
  localparam int SEC_W   = 8;
  localparam int COORD_W = 16;
  localparam int NORM_W  = 16;
  localparam int CURV_W  = 16;
  localparam int STEP_W  = 12;
  localparam int ZLIM_W  = 15;
  localparam int CORNER_W = 2;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // radius, squared radius and products of the coordinate path
  localparam int R_W     = RING_W + 1 + STEP_W;
  localparam int R2_W    = 2 * R_W;
  localparam int PR_W    = R_W + TMAG_W;
  localparam int CM_W    = CURV_W;
  localparam int ZP_W    = CM_W + R_W;
  localparam int ZS_W    = CM_W + R2_W + 1;
  localparam int ZM_W    = ZS_W + 1;
  localparam int Z_SHIFT = 22;
  localparam int Z_ROUND = 1 << (Z_SHIFT - 1);

  // normal path
  localparam int CR_W       = 2 * (COORD_W + 1) + 1;
  localparam int MAG_W      = CR_W - 1;
  localparam int POS_W      = $clog2(MAG_W);
  localparam int NM_W       = 30;
  localparam int SUM_W      = 2 * NM_W + 2;
  localparam int SQ_W       = SUM_W + 1;
  localparam int SQRT_STEPS = SUM_W / 2 + 1;
  localparam int LEN_W      = SUM_W / 2;
  localparam int Q_W        = 15;
  localparam int DIV_STEPS  = Q_W;
  localparam int N_W        = NM_W + Q_W + 1;
  localparam int NORM_LAT   = 5 + SQRT_STEPS + 1 + DIV_STEPS + 1;

  localparam logic [CORNER_W-1:0] CORNER_LAST = 2'd2;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1073741824;

  // Taylor series term divisors: (2k)(2k+1) for sine, (2k-1)(2k) for cosine
  localparam longint unsigned SIN_DIV [10] = '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420};
  localparam longint unsigned COS_DIV [10] = '{2, 12, 30, 56, 90, 132, 182, 240, 306, 380};

  typedef enum logic [1:0] {
    REG_CURVATURE,
    REG_RADIUS_STEP,
    REG_Z_LIMIT,
    REG_LAST_RING
  } reg_idx_t;

  typedef logic signed [TRIG_BITS-1:0] trig_t;
  typedef trig_t trig_tab_t [SECTOR_COUNT];
  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vtx_t;

  typedef struct packed {
    vtx_t [2:0] v;
    logic       bad;
  } tri_t;

  typedef struct packed {
    logic signed [CR_W-1:0] x;
    logic signed [CR_W-1:0] y;
    logic signed [CR_W-1:0] z;
  } cross_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] x;
    logic signed [NORM_W-1:0] y;
    logic signed [NORM_W-1:0] z;
  } nvec_t;

  function automatic trig_tab_t build_trig(input bit want_cos);
    trig_tab_t tab;
    longint unsigned four, q, rest, th, ts, tc, m;
    longint s, c, sv, cv, v;
    for (int i = 0; i < SECTOR_COUNT; i++) begin
      four = 4 * longint'(i);
      q    = four / SECTOR_COUNT;
      rest = four - q * SECTOR_COUNT;
      th   = HALF_PI_Q30 * rest / SECTOR_COUNT;
      ts   = th;
      tc   = ONE_Q30;
      s    = longint'(th);
      c    = longint'(ONE_Q30);
      for (int k = 1; k <= 10; k++) begin
        ts = (ts * th) >> 30;
        ts = ((ts * th) >> 30) / SIN_DIV[k-1];
        tc = (tc * th) >> 30;
        tc = ((tc * th) >> 30) / COS_DIV[k-1];
        if (k % 2 == 1) begin
          s = s - longint'(ts);
          c = c - longint'(tc);
        end else begin
          s = s + longint'(ts);
          c = c + longint'(tc);
        end
      end
      case (q % 4)
        0: begin sv = s;  cv = c;  end
        1: begin sv = c;  cv = -s; end
        2: begin sv = -s; cv = -c; end
        default: begin sv = -c; cv = s; end
      endcase
      v = want_cos ? cv : sv;
      m = (v < 0) ? longint'(-v) : longint'(v);
      m = (m + (64'd1 << (29 - TRIG_FRAC))) >> (30 - TRIG_FRAC);
      tab[i] = (v < 0) ? trig_t'(-longint'(m)) : trig_t'(m);
    end
    return tab;
  endfunction

  localparam trig_tab_t SIN_TAB = build_trig(1'b0);
  localparam trig_tab_t COS_TAB = build_trig(1'b1);

  function automatic logic [TMAG_W-1:0] trig_mag(input trig_t t);
    return t[TRIG_BITS-1] ? TMAG_W'(-t) : TMAG_W'(t);
  endfunction

  // round half away from zero, then saturate to the coordinate range
  function automatic coord_t scale_coord(input logic [PR_W-1:0] p, input logic neg);
    logic [PR_W:0] m;
    m = ({1'b0, p} + (PR_W+1)'(1 << (TRIG_FRAC - 1))) >> TRIG_FRAC;
    if (!neg) return (m > 32767) ? coord_t'(16'h7FFF) : coord_t'(m);
    return (m > 32768) ? coord_t'(16'h8000) : coord_t'(-m);
  endfunction

  function automatic coord_t sat_height(input logic [ZM_W-1:0] zm, input logic neg);
    if (!neg) return (zm > 32767) ? coord_t'(16'h7FFF) : coord_t'(zm);
    return (zm > 32768) ? coord_t'(16'h8000) : coord_t'(-zm);
  endfunction

endpackage
`default_nettype wire

[hdl/ptg_if.sv]
`default_nettype none
interface ptg_req_if import ptg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RING_W-1:0] ring_index;
  logic [SEC_W-1:0]  sector_index;
  logic              quad_half;

  modport source (output valid, ring_index, sector_index, quad_half, input ready);
  modport sink   (input valid, ring_index, sector_index, quad_half, output ready);
endinterface

interface ptg_res_if import ptg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic signed [15:0]  vertex_x;
  logic signed [15:0]  vertex_y;
  logic signed [15:0]  vertex_z;
  logic signed [15:0]  normal_x;
  logic signed [15:0]  normal_y;
  logic signed [15:0]  normal_z;
  logic [CORNER_W-1:0] corner;
  logic                rejected;
  logic                last_of_triangle;

  modport source (output valid, vertex_x, vertex_y, vertex_z, normal_x, normal_y, normal_z,
                  corner, rejected, last_of_triangle, input ready);
  modport sink   (input valid, vertex_x, vertex_y, vertex_z, normal_x, normal_y, normal_z,
                  corner, rejected, last_of_triangle, output ready);
endinterface
`default_nettype wire

[hdl/ptg_normal.sv]
`default_nettype none
module ptg_normal import ptg_pkg::*; (
  input  logic   clk,
  input  logic   ce,
  input  cross_t cr,
  output nvec_t  nrm
);

  typedef struct packed {
    logic [2:0][NM_W-1:0] nm;
    logic [2:0]           neg;
    logic                 zero;
  } nside_t;

  typedef struct packed {
    logic [SQ_W-1:0] x;
    logic [SQ_W-1:0] res;
    nside_t          side;
  } sq_t;

  typedef struct packed {
    logic [2:0][N_W-1:0] rem;
    logic [2:0][Q_W-1:0] q;
    logic [LEN_W:0]      den;
    logic [2:0]          neg;
    logic                zero;
  } dv_t;

  logic signed [CR_W-1:0] cin [3];
  assign cin[0] = cr.x;
  assign cin[1] = cr.y;
  assign cin[2] = cr.z;

  // magnitudes and the largest of them
  logic [MAG_W-1:0] mag_c [3];
  logic [MAG_W-1:0] mx_c;
  logic [MAG_W-1:0] a_mag [3];
  logic [2:0]       a_neg;
  logic [MAG_W-1:0] a_mx;

  always_comb begin
    mx_c = '0;
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = cin[i][CR_W-1] ? MAG_W'(-cin[i]) : MAG_W'(cin[i]);
      if (mag_c[i] > mx_c) mx_c = mag_c[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        a_mag[i] <= mag_c[i];
        a_neg[i] <= cin[i][CR_W-1];
      end
      a_mx <= mx_c;
    end
  end

  // leading one of the largest magnitude
  logic [POS_W-1:0] pos_c;
  logic [MAG_W-1:0] b_mag [3];
  logic [2:0]       b_neg;
  logic [POS_W-1:0] b_pos;
  logic             b_zero;

  always_comb begin
    pos_c = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (a_mx[i]) pos_c = POS_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      b_mag  <= a_mag;
      b_neg  <= a_neg;
      b_pos  <= pos_c;
      b_zero <= (a_mx == '0);
    end
  end

  // bring the largest magnitude into [2^29, 2^30)
  nside_t c_side;
  nside_t c_side_next;

  always_comb begin
    c_side_next.neg  = b_neg;
    c_side_next.zero = b_zero;
    for (int i = 0; i < 3; i++) begin
      if (int'(b_pos) < NM_W - 1) begin
        c_side_next.nm[i] = NM_W'(b_mag[i] << (NM_W - 1 - int'(b_pos)));
      end else begin
        c_side_next.nm[i] = NM_W'(b_mag[i] >> (int'(b_pos) - (NM_W - 1)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) c_side <= c_side_next;
  end

  logic [2*NM_W-1:0] sq_c [3];
  logic [2*NM_W-1:0] d_sq [3];
  nside_t            d_side;

  always_comb begin
    for (int i = 0; i < 3; i++) sq_c[i] = c_side.nm[i] * c_side.nm[i];
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      d_sq   <= sq_c;
      d_side <= c_side;
    end
  end

  sq_t sq [SQRT_STEPS+1];
  logic [SUM_W-1:0] sum_c;
  assign sum_c = SUM_W'(d_sq[0]) + SUM_W'(d_sq[1]) + SUM_W'(d_sq[2]);

  always_ff @(posedge clk) begin
    if (ce) begin
      sq[0].x    <= SQ_W'(sum_c);
      sq[0].res  <= '0;
      sq[0].side <= d_side;
    end
  end

  // integer square root, one result bit per stage
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [SQ_W-1:0] BITV = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - k));
    sq_t             nx;
    logic [SQ_W-1:0] trial;

    always_comb begin
      nx    = sq[k];
      trial = sq[k].res + BITV;
      if (sq[k].x >= trial) begin
        nx.x   = sq[k].x - trial;
        nx.res = (sq[k].res >> 1) + BITV;
      end else begin
        nx.res = sq[k].res >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) sq[k+1] <= nx;
    end
  end

  dv_t dv [DIV_STEPS+1];
  logic [LEN_W-1:0] len;
  assign len = sq[SQRT_STEPS].res[LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        dv[0].rem[i] <= (N_W'(sq[SQRT_STEPS].side.nm[i]) << Q_W) + N_W'(len);
      end
      dv[0].q    <= '0;
      dv[0].den  <= {len, 1'b0};
      dv[0].neg  <= sq[SQRT_STEPS].side.neg;
      dv[0].zero <= sq[SQRT_STEPS].side.zero;
    end
  end

  // restoring division, one quotient bit per stage, three lanes
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    localparam int QB = DIV_STEPS - 1 - k;
    dv_t            nx;
    logic [N_W-1:0] sub;

    always_comb begin
      nx  = dv[k];
      sub = N_W'(dv[k].den) << QB;
      for (int i = 0; i < 3; i++) begin
        if (dv[k].rem[i] >= sub) begin
          nx.rem[i]    = dv[k].rem[i] - sub;
          nx.q[i][QB]  = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (ce) dv[k+1] <= nx;
    end
  end

  logic signed [NORM_W-1:0] n_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv[DIV_STEPS].zero) begin
        n_c[i] = '0;
      end else if (dv[DIV_STEPS].neg[i]) begin
        n_c[i] = -NORM_W'(dv[DIV_STEPS].q[i]);
      end else begin
        n_c[i] = NORM_W'(dv[DIV_STEPS].q[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      nrm.x <= n_c[0];
      nrm.y <= n_c[1];
      nrm.z <= n_c[2];
    end
  end

endmodule
`default_nettype wire

[hdl/paraboloid_triangle_generator.sv]
`default_nettype none
// Triangle generator for the paraboloid z = curvature * r^2, ring radius (ring + 1) * step.
// Each accepted request gives three vertex beats (corner 0, 1, 2) carrying the same unit face
// normal, or one beat with rejected set for a bad sector, a ring beyond last_ring or a ring
// other than 0 whose height exceeds z_limit. The core is a fully pipelined datapath that
// takes a request in every cycle while it is not stalled: four stages of coordinate arithmetic,
// three for the cross product, then the normal unit (square root one bit a stage, division one
// quotient bit a stage). The single result port sets the sustained rate: three beats per
// request, one beat per rejected request. A stall on the result side freezes the whole
// pipeline. Registers sit on an APB port at 4*index and must only be written while the block
// is idle.
module paraboloid_triangle_generator import ptg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  ptg_req_if.sink            in_ch,
  ptg_res_if.source          out_ch
);

  localparam int DL_LEN = 3 + NORM_LAT;

  // configuration registers
  logic signed [CURV_W-1:0] curvature;
  logic [STEP_W-1:0]        radius_step;
  logic [ZLIM_W-1:0]        z_limit;
  logic [RING_W-1:0]        last_ring;
  reg_idx_t                 reg_sel;

  assign reg_sel = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      curvature   <= 16'sd1024;
      radius_step <= 12'd205;
      z_limit     <= 15'd20480;
      last_ring   <= 7'd98;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_CURVATURE:   curvature   <= pwdata[CURV_W-1:0];
        REG_RADIUS_STEP: radius_step <= pwdata[STEP_W-1:0];
        REG_Z_LIMIT:     z_limit     <= pwdata[ZLIM_W-1:0];
        REG_LAST_RING:   last_ring   <= pwdata[RING_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_CURVATURE:   prdata = {{(PDATA_W-CURV_W){curvature[CURV_W-1]}}, curvature};
      REG_RADIUS_STEP: prdata = PDATA_W'(radius_step);
      REG_Z_LIMIT:     prdata = PDATA_W'(z_limit);
      REG_LAST_RING:   prdata = PDATA_W'(last_ring);
      default:         prdata = '0;
    endcase
  end

  // pipeline control
  logic             ce;
  logic             buf_valid;
  logic             buf_last;
  logic [3:0]       vld;
  logic [DL_LEN-1:0] vdl;
  logic [CORNER_W-1:0] cnt;
  tri_t             buf_tri;
  nvec_t            buf_nrm;

  assign buf_last    = buf_tri.bad || (cnt == CORNER_LAST);
  assign ce          = !buf_valid || (out_ch.ready && buf_last);
  assign in_ch.ready = ce && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      vdl <= '0;
    end else if (ce) begin
      vld <= {vld[2:0], in_ch.valid};
      vdl <= {vdl[DL_LEN-2:0], vld[3]};
    end
  end

  // stage 1: radii, range checks, table lookups
  logic [RING_W:0]   rp1;
  logic [SEC_W:0]    sec_nx;
  logic [R_W-1:0]    ra_c, rb_c;
  logic              sec_ok;
  logic [SIDX_W-1:0] idx_s, idx_s1;

  assign rp1    = {1'b0, in_ch.ring_index} + 1'b1;
  assign sec_nx = {1'b0, in_ch.sector_index} + 1'b1;
  assign ra_c   = rp1 * radius_step;
  assign rb_c   = in_ch.ring_index * radius_step;
  assign sec_ok = in_ch.sector_index < SECTOR_COUNT;
  assign idx_s  = sec_ok ? SIDX_W'(in_ch.sector_index) : '0;
  assign idx_s1 = (sec_nx >= SECTOR_COUNT) ? '0 : SIDX_W'(sec_nx);

  logic [RING_W-1:0] s1_ring;
  logic              s1_half, s1_bad;
  logic [R_W-1:0]    s1_ra, s1_rb;
  logic [TMAG_W-1:0] s1_tm [4];
  logic [3:0]        s1_tn;

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_ring  <= in_ch.ring_index;
      s1_half  <= in_ch.quad_half;
      s1_bad   <= !sec_ok || (in_ch.ring_index > last_ring) ||
                  (int'(in_ch.ring_index) >= MAX_RINGS);
      s1_ra    <= ra_c;
      s1_rb    <= rb_c;
      s1_tm[0] <= trig_mag(SIN_TAB[idx_s]);
      s1_tm[1] <= trig_mag(COS_TAB[idx_s]);
      s1_tm[2] <= trig_mag(SIN_TAB[idx_s1]);
      s1_tm[3] <= trig_mag(COS_TAB[idx_s1]);
      s1_tn    <= {COS_TAB[idx_s1][TRIG_BITS-1], SIN_TAB[idx_s1][TRIG_BITS-1],
                   COS_TAB[idx_s][TRIG_BITS-1], SIN_TAB[idx_s][TRIG_BITS-1]};
    end
  end

  // stage 2: squared radii and radius * trig products
  logic [R2_W-1:0] ra2_c, rb2_c;
  logic [PR_W-1:0] p_c [8];

  assign ra2_c = s1_ra * s1_ra;
  assign rb2_c = s1_rb * s1_rb;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      p_c[i]     = s1_ra * s1_tm[i];
      p_c[i + 4] = s1_rb * s1_tm[i];
    end
  end

  logic [RING_W-1:0] s2_ring;
  logic              s2_half, s2_bad;
  logic [R2_W-1:0]   s2_ra2, s2_rb2;
  logic [PR_W-1:0]   s2_p [8];
  logic [3:0]        s2_tn;

  always_ff @(posedge clk) begin
    if (ce) begin
      s2_ring <= s1_ring;
      s2_half <= s1_half;
      s2_bad  <= s1_bad;
      s2_ra2  <= ra2_c;
      s2_rb2  <= rb2_c;
      s2_p    <= p_c;
      s2_tn   <= s1_tn;
    end
  end

  // stage 3: height partial products, rounded coordinates
  logic [CM_W-1:0] cm;
  logic [ZP_W-1:0] zal_c, zah_c, zbl_c, zbh_c;
  coord_t          xy_c [8];

  assign cm    = curvature[CURV_W-1] ? CM_W'(-curvature) : CM_W'(curvature);
  assign zal_c = cm * s2_ra2[R_W-1:0];
  assign zah_c = cm * s2_ra2[R2_W-1:R_W];
  assign zbl_c = cm * s2_rb2[R_W-1:0];
  assign zbh_c = cm * s2_rb2[R2_W-1:R_W];

  always_comb begin
    for (int i = 0; i < 8; i++) xy_c[i] = scale_coord(s2_p[i], s2_tn[i % 4]);
  end

  logic [RING_W-1:0] s3_ring;
  logic              s3_half, s3_bad;
  logic [ZP_W-1:0]   s3_zal, s3_zah, s3_zbl, s3_zbh;
  coord_t            s3_xy [8];

  always_ff @(posedge clk) begin
    if (ce) begin
      s3_ring <= s2_ring;
      s3_half <= s2_half;
      s3_bad  <= s2_bad;
      s3_zal  <= zal_c;
      s3_zah  <= zah_c;
      s3_zbl  <= zbl_c;
      s3_zbh  <= zbh_c;
      s3_xy   <= xy_c;
    end
  end

  // stage 4: heights, height check, corner selection
  logic [ZS_W-1:0] zsa, zsb;
  logic [ZM_W-1:0] zma, zmb;
  coord_t          za, zb;
  vtx_t            va_s, va_s1, vb_s, vb_s1;
  tri_t            tri_c;
  logic            too_high;

  assign zsa = (ZS_W'(s3_zah) << R_W) + ZS_W'(s3_zal);
  assign zsb = (ZS_W'(s3_zbh) << R_W) + ZS_W'(s3_zbl);
  assign zma = ({1'b0, zsa} + ZM_W'(Z_ROUND)) >> Z_SHIFT;
  assign zmb = ({1'b0, zsb} + ZM_W'(Z_ROUND)) >> Z_SHIFT;
  assign za  = sat_height(zma, curvature[CURV_W-1]);
  assign zb  = sat_height(zmb, curvature[CURV_W-1]);
  assign too_high = (s3_ring != '0) && (zma > ZM_W'(z_limit));

  assign va_s  = '{x: s3_xy[0], y: s3_xy[1], z: za};
  assign va_s1 = '{x: s3_xy[2], y: s3_xy[3], z: za};
  assign vb_s  = '{x: s3_xy[4], y: s3_xy[5], z: zb};
  assign vb_s1 = '{x: s3_xy[6], y: s3_xy[7], z: zb};

  always_comb begin
    tri_c.bad = s3_bad || too_high;
    if (tri_c.bad) begin
      tri_c.v = '0;
    end else if (s3_ring == '0) begin
      tri_c.v[0] = va_s;
      tri_c.v[1] = va_s1;
      tri_c.v[2] = '0;
    end else if (!s3_half) begin
      tri_c.v[0] = va_s1;
      tri_c.v[1] = va_s;
      tri_c.v[2] = vb_s;
    end else begin
      tri_c.v[0] = vb_s;
      tri_c.v[1] = vb_s1;
      tri_c.v[2] = va_s1;
    end
  end

  tri_t s4_tri;

  always_ff @(posedge clk) begin
    if (ce) s4_tri <= tri_c;
  end

  // stages 5 to 7: edge vectors and cross product
  typedef logic signed [COORD_W:0]      diff_t;
  typedef logic signed [2*COORD_W+1:0]  prod_t;

  diff_t u_c [3];
  diff_t w_c [3];
  diff_t s5_u [3];
  diff_t s5_w [3];
  coord_t c0 [3];
  coord_t c1 [3];
  coord_t c2 [3];

  assign c0[0] = s4_tri.v[0].x;
  assign c0[1] = s4_tri.v[0].y;
  assign c0[2] = s4_tri.v[0].z;
  assign c1[0] = s4_tri.v[1].x;
  assign c1[1] = s4_tri.v[1].y;
  assign c1[2] = s4_tri.v[1].z;
  assign c2[0] = s4_tri.v[2].x;
  assign c2[1] = s4_tri.v[2].y;
  assign c2[2] = s4_tri.v[2].z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_c[i] = {c0[i][COORD_W-1], c0[i]} - {c1[i][COORD_W-1], c1[i]};
      w_c[i] = {c1[i][COORD_W-1], c1[i]} - {c2[i][COORD_W-1], c2[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s5_u <= u_c;
      s5_w <= w_c;
    end
  end

  prod_t s6_p [6];

  always_ff @(posedge clk) begin
    if (ce) begin
      s6_p[0] <= s5_u[1] * s5_w[2];
      s6_p[1] <= s5_u[2] * s5_w[1];
      s6_p[2] <= s5_u[2] * s5_w[0];
      s6_p[3] <= s5_u[0] * s5_w[2];
      s6_p[4] <= s5_u[0] * s5_w[1];
      s6_p[5] <= s5_u[1] * s5_w[0];
    end
  end

  cross_t s7_cr;

  always_ff @(posedge clk) begin
    if (ce) begin
      s7_cr.x <= {s6_p[0][2*COORD_W+1], s6_p[0]} - {s6_p[1][2*COORD_W+1], s6_p[1]};
      s7_cr.y <= {s6_p[2][2*COORD_W+1], s6_p[2]} - {s6_p[3][2*COORD_W+1], s6_p[3]};
      s7_cr.z <= {s6_p[4][2*COORD_W+1], s6_p[4]} - {s6_p[5][2*COORD_W+1], s6_p[5]};
    end
  end

  nvec_t nrm;

  ptg_normal u_normal (
    .clk (clk),
    .ce  (ce),
    .cr  (s7_cr),
    .nrm (nrm)
  );

  // hold the corners alongside the normal unit
  tri_t dl [DL_LEN];

  always_ff @(posedge clk) begin
    if (ce) begin
      dl[0] <= s4_tri;
      for (int k = 1; k < DL_LEN; k++) dl[k] <= dl[k-1];
    end
  end

  // output buffer, one triangle, emitted a beat per corner, or a single beat if rejected
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      cnt       <= '0;
    end else if (ce) begin
      buf_valid <= vdl[DL_LEN-1];
      cnt       <= '0;
    end else if (out_ch.ready) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      buf_tri <= dl[DL_LEN-1];
      buf_nrm <= nrm;
    end
  end

  vtx_t sel_v;
  assign sel_v = buf_tri.v[cnt];

  assign out_ch.valid            = buf_valid;
  assign out_ch.vertex_x         = sel_v.x;
  assign out_ch.vertex_y         = sel_v.y;
  assign out_ch.vertex_z         = sel_v.z;
  assign out_ch.normal_x         = buf_nrm.x;
  assign out_ch.normal_y         = buf_nrm.y;
  assign out_ch.normal_z         = buf_nrm.z;
  assign out_ch.corner           = cnt;
  assign out_ch.rejected         = buf_tri.bad;
  assign out_ch.last_of_triangle = buf_last;

endmodule
`default_nettype wire

[tb/testbench.sv]
`default_nettype none
module testbench;
  import ptg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] vz;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic [1:0]         corner;
    logic               rejected;
    logic               last;
  } vertex_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic               psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  ptg_req_if req_ch ();
  ptg_res_if res_ch ();

  paraboloid_triangle_generator uut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_ch(req_ch), .out_ch(res_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // register shadow
  longint curv_q10 = 1024;
  longint unsigned step_q12 = 205;
  longint unsigned zlim_q12 = 20480;
  longint unsigned last_ring_idx = 98;

  longint sin_lut [SECTOR_COUNT];
  longint cos_lut [SECTOR_COUNT];

  vertex_beat_t expected_beats [$];
  int  mismatches = 0;
  bit  calm = 1'b0;
  int  hold_request = 0;
  int  stall_left = 0;

  function automatic void enqueue_beat(vertex_beat_t b);
    expected_beats = {expected_beats, b};
  endfunction

  function automatic longint round_trig(longint v);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : longint'(v);
    m = (m + (64'd1 << 15)) >> 16;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  task automatic fill_trig_luts();
    longint unsigned four, quad, rest, th, ts, tc;
    longint s, c, sv, cv;
    for (int i = 0; i < SECTOR_COUNT; i++) begin
      four = 4 * i;
      quad = four / SECTOR_COUNT;
      rest = four - quad * SECTOR_COUNT;
      th = 64'd1686629713 * rest / SECTOR_COUNT;
      ts = th;
      tc = 64'd1073741824;
      s = longint'(th);
      c = longint'(tc);
      for (int k = 1; k <= 10; k++) begin
        ts = (ts * th) >> 30;
        ts = ((ts * th) >> 30) / longint'((2 * k) * (2 * k + 1));
        tc = (tc * th) >> 30;
        tc = ((tc * th) >> 30) / longint'((2 * k - 1) * (2 * k));
        if (k % 2 == 1) begin
          s -= longint'(ts);
          c -= longint'(tc);
        end else begin
          s += longint'(ts);
          c += longint'(tc);
        end
      end
      case (quad % 4)
        0: begin sv = s; cv = c; end
        1: begin sv = c; cv = -s; end
        2: begin sv = -s; cv = -c; end
        default: begin sv = -c; cv = s; end
      endcase
      sin_lut[i] = round_trig(sv);
      cos_lut[i] = round_trig(cv);
    end
  endtask

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint radial_coord(longint unsigned r, longint t);
    longint unsigned m;
    m = r * longint'((t < 0) ? -t : t);
    m = (m + (64'd1 << 13)) >> 14;
    if (m > 40000) m = 40000;
    return clamp16((t < 0) ? -longint'(m) : longint'(m));
  endfunction

  function automatic longint unsigned height_of(longint unsigned r);
    longint unsigned c;
    c = (curv_q10 < 0) ? longint'(-curv_q10) : longint'(curv_q10);
    return (c * r * r + (64'd1 << 21)) >> 22;
  endfunction

  task automatic ring_point(int ring, int sec, output longint p [3]);
    longint unsigned r, zm;
    int s;
    r = longint'(ring + 1) * step_q12;
    zm = height_of(r);
    s = sec % SECTOR_COUNT;
    p[0] = radial_coord(r, sin_lut[s]);
    p[1] = radial_coord(r, cos_lut[s]);
    if (curv_q10 < 0) p[2] = (zm > 32768) ? -32768 : -longint'(zm);
    else p[2] = (zm > 32767) ? 32767 : longint'(zm);
  endtask

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else res >>= 1;
      bitv >>= 2;
    end
    return res;
  endfunction

  task automatic unit_normal(input longint a [3], input longint b [3], input longint c [3],
                             output longint n [3]);
    longint u [3], w [3], cr [3];
    longint unsigned mag [3], mx, sum, len;
    mx = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      u[i] = a[i] - b[i];
      w[i] = b[i] - c[i];
    end
    cr[0] = u[1] * w[2] - u[2] * w[1];
    cr[1] = u[2] * w[0] - u[0] * w[2];
    cr[2] = u[0] * w[1] - u[1] * w[0];
    for (int i = 0; i < 3; i++) begin
      mag[i] = (cr[i] < 0) ? longint'(-cr[i]) : longint'(cr[i]);
      if (mag[i] > mx) mx = mag[i];
      n[i] = 0;
    end
    if (mx != 0) begin
      while (mx < (64'd1 << 29)) begin
        mx <<= 1;
        for (int i = 0; i < 3; i++) mag[i] <<= 1;
      end
      while (mx >= (64'd1 << 30)) begin
        mx >>= 1;
        for (int i = 0; i < 3; i++) mag[i] >>= 1;
      end
      for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
      len = int_sqrt(sum);
      if (len != 0)
        for (int i = 0; i < 3; i++) begin
          mx = (2 * mag[i] * 16384 + len) / (2 * len);
          n[i] = (cr[i] < 0) ? -longint'(mx) : longint'(mx);
        end
    end
  endtask

  task automatic predict_triangle(int ring, int sec, bit half);
    longint v0 [3], v1 [3], v2 [3], n [3];
    longint pts [3][3];
    vertex_beat_t b;
    bit bad;
    bad = (sec >= SECTOR_COUNT) || (ring > last_ring_idx) || (ring >= MAX_RINGS);
    if (!bad && ring > 0 && height_of(longint'(ring + 1) * step_q12) > zlim_q12) bad = 1'b1;
    if (bad) begin
      b = '0;
      b.rejected = 1'b1;
      b.last = 1'b1;
      enqueue_beat(b);
    end else begin
      if (ring == 0) begin
        ring_point(0, sec, v0);
        ring_point(0, sec + 1, v1);
        v2 = '{0, 0, 0};
      end else if (!half) begin
        ring_point(ring, sec + 1, v0);
        ring_point(ring, sec, v1);
        ring_point(ring - 1, sec, v2);
      end else begin
        ring_point(ring - 1, sec, v0);
        ring_point(ring - 1, sec + 1, v1);
        ring_point(ring, sec + 1, v2);
      end
      unit_normal(v0, v1, v2, n);
      pts[0] = v0;
      pts[1] = v1;
      pts[2] = v2;
      for (int k = 0; k < 3; k++) begin
        b.vx = 16'(pts[k][0]);
        b.vy = 16'(pts[k][1]);
        b.vz = 16'(pts[k][2]);
        b.nx = 16'(n[0]);
        b.ny = 16'(n[1]);
        b.nz = 16'(n[2]);
        b.corner = 2'(k);
        b.rejected = 1'b0;
        b.last = (k == 2);
        enqueue_beat(b);
      end
    end
  endtask

  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  // sender: valid stays high across back-to-back beats
  task automatic send_request(int ring, int sec, bit half);
    int gap;
    gap = (calm || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.ring_index <= RING_W'(ring);
    req_ch.sector_index <= SEC_W'(sec);
    req_ch.quad_half <= half;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predict_triangle(ring, sec, half);
  endtask

  task automatic settle();
    if (req_ch.valid) req_ch.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, longint value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_CURVATURE:   curv_q10 = longint'($signed(16'(value)));
      REG_RADIUS_STEP: step_q12 = value & 64'hFFF;
      REG_Z_LIMIT:     zlim_q12 = value & 64'h7FFF;
      REG_LAST_RING:   last_ring_idx = value & 64'h7F;
      default: ;
    endcase
  endtask

  task automatic random_request();
    int ring, sec, lim;
    lim = (last_ring_idx < 15) ? int'(last_ring_idx) : 15;
    case ($urandom_range(0, 19))
      0, 1, 2:    ring = $urandom_range(0, 127);
      3, 4, 5, 6: ring = $urandom_range(0, int'(last_ring_idx));
      default:    ring = $urandom_range(0, lim);
    endcase
    sec = ($urandom_range(0, 6) == 0) ? $urandom_range(200, 255) : $urandom_range(0, 199);
    send_request(ring, sec, 1'($urandom_range(0, 1)));
  endtask

  task automatic test_directed();
    send_request(0, 0, 1'b0);
    send_request(0, 199, 1'b1);
    send_request(0, 100, 1'b0);
    send_request(0, 200, 1'b0);
    send_request(0, 255, 1'b1);
    send_request(1, 0, 1'b0);
    send_request(1, 0, 1'b1);
    send_request(5, 199, 1'b0);
    send_request(5, 199, 1'b1);
    send_request(10, 50, 1'b1);
    send_request(12, 60, 1'b0);
    send_request(98, 10, 1'b0);
    send_request(99, 10, 1'b1);
    send_request(127, 127, 1'b1);
    send_request(3, 200, 1'b1);
    settle();
    write_reg(REG_LAST_RING, 3);
    send_request(3, 7, 1'b0);
    send_request(4, 7, 1'b0);
    settle();
  endtask

  task automatic test_setting(longint c, longint s, longint z, longint l, int count);
    write_reg(REG_CURVATURE, c);
    write_reg(REG_RADIUS_STEP, s);
    write_reg(REG_Z_LIMIT, z);
    write_reg(REG_LAST_RING, l);
    calm = 1'b0;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) calm = 1'b1;
      if (i == count / 2 + 10) calm = 1'b0;
      random_request();
    end
    settle();
  endtask

  // hold the result side while requests keep coming, so the pipe fills and stalls
  task automatic test_backpressure();
    write_reg(REG_CURVATURE, 1024);
    write_reg(REG_RADIUS_STEP, 205);
    write_reg(REG_Z_LIMIT, 20480);
    write_reg(REG_LAST_RING, 98);
    calm = 1'b1;
    hold_request = 400;
    for (int i = 0; i < 60; i++) random_request();
    calm = 1'b0;
    settle();
  endtask

  always @(posedge clk) begin
    if (hold_request > 0) begin
      stall_left = hold_request;
      hold_request = 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      res_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      stall_left = pick_gap() - 1;
      res_ch.ready <= 1'b0;
    end else res_ch.ready <= 1'b1;
  end

  always @(posedge clk) begin
    vertex_beat_t got, want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = '{res_ch.vertex_x, res_ch.vertex_y, res_ch.vertex_z, res_ch.normal_x,
              res_ch.normal_y, res_ch.normal_z, res_ch.corner, res_ch.rejected,
              res_ch.last_of_triangle};
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %p", got);
      end else begin
        want = expected_beats.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("beat mismatch\n  expected %p\n  actual   %p", want, got);
        end
      end
    end
  end

  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    req_ch.valid <= 1'b0;
    req_ch.ring_index <= '0;
    req_ch.sector_index <= '0;
    req_ch.quad_half <= 1'b0;
    fill_trig_luts();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_setting(1024, 205, 20480, 98, 80);
    test_setting(0, 4095, 32767, 127, 60);
    test_setting(-32768, 1, 0, 0, 40);
    test_setting(32767, 300, 20000, 127, 60);
    test_setting(-500, 50, 3000, 60, 60);
    test_backpressure();
    if (mismatches == 0 && expected_beats.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
`default_nettype wire

[filelist.f]
hdl/ptg_pkg.sv
hdl/ptg_if.sv
hdl/ptg_normal.sv
hdl/paraboloid_triangle_generator.sv
tb/testbench.sv
